>>> sv/ipv4p_pkg.sv
// Shared types and constants for the IPv4 dotted-decimal parser.
// Used by the channel interfaces and every module of the block; no dependencies.
package ipv4p_pkg;

	// Character codes that the front end recognizes.
	localparam logic [7:0] CHAR_END  = 8'h00;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// Octet limits and the saturated value that marks an overflow.
	localparam int unsigned OCTET_W = 9;
	localparam logic [OCTET_W-1:0] OCTET_MAX = 9'd255;
	localparam logic [OCTET_W-1:0] OCTET_SAT = 9'd256;

	// Number of the last octet, counting from zero.
	localparam logic [1:0] LAST_INDEX = 2'd3;

	// Depth of the queue between front end and back end (a power of two).
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Class of one input character.
	typedef enum logic [1:0] {
		KIND_DIGIT,
		KIND_DOT,
		KIND_END,
		KIND_OTHER
	} char_kind_t;

	// A classified character as it travels through the queue.
	typedef struct packed {
		char_kind_t kind;
		logic [3:0] digit;
	} ipv4p_item_t;

	// Phase of the octet being parsed.
	typedef enum logic {
		PHASE_FIRST,
		PHASE_DIGITS
	} parse_phase_t;

endpackage

>>> sv/ipv4p_if.sv
// Valid/ready channel interfaces for the character input and the result output.
// Each interface imports ipv4p_pkg; the payload widths follow the character and address formats.
interface ipv4p_char_if;
	import ipv4p_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

interface ipv4p_result_if;
	import ipv4p_pkg::*;

	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic        parse_error;

	modport source (output valid, output address, output parse_error, input ready);
	modport sink (input valid, input address, input parse_error, output ready);
endinterface

>>> sv/ipv4p_front.sv
// Front end: accepts characters and classifies them as digit, dot, end or other.
// Depends on ipv4p_pkg and ipv4p_char_if.
module ipv4p_front (
	ipv4p_char_if.sink               chars,
	output ipv4p_pkg::ipv4p_item_t   item,
	output logic                     item_valid,
	input  logic                     item_ready
);
	import ipv4p_pkg::*;

	logic [7:0] digit_off;

	// A transaction passes straight on to the queue when it has room.
	assign chars.ready = item_ready;
	assign item_valid  = chars.valid;

	// Classify the character and extract the digit value.
	assign digit_off = chars.char_in - CHAR_ZERO;

	always_comb begin
		item.digit = digit_off[3:0];
		if (chars.char_in == CHAR_END) begin
			item.kind = KIND_END;
		end else if (chars.char_in == CHAR_DOT) begin
			item.kind = KIND_DOT;
		end else if (chars.char_in >= CHAR_ZERO && chars.char_in <= CHAR_NINE) begin
			item.kind = KIND_DIGIT;
		end else begin
			item.kind = KIND_OTHER;
		end
	end

endmodule

>>> sv/ipv4p_queue.sv
// Short first-in first-out queue of classified characters between the two halves.
// Depends on ipv4p_pkg for the item type and the queue depth.
module ipv4p_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ipv4p_pkg::ipv4p_item_t push_item,
	input  logic                   push_valid,
	output logic                   push_ready,
	output ipv4p_pkg::ipv4p_item_t head_item,
	output logic                   head_valid,
	input  logic                   pop
);
	import ipv4p_pkg::*;

	ipv4p_item_t         store_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = store_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	// Entry storage; written at the tail only.
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> sv/ipv4p_back.sv
// Back end: runs the octet parser on classified characters and holds the result.
// Depends on ipv4p_pkg and ipv4p_result_if.
module ipv4p_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ipv4p_pkg::ipv4p_item_t head_item,
	input  logic                   head_valid,
	output logic                   pop,
	ipv4p_result_if.source         result
);
	import ipv4p_pkg::*;

	logic [1:0]         octet_index_q;
	parse_phase_t       phase_q;
	logic [OCTET_W-1:0] octet_value_q;
	logic [23:0]        address_acc_q;
	logic               error_seen_q;
	logic               out_valid_q;
	logic [31:0]        out_address_q;
	logic               out_error_q;

	logic [11:0]        digit_sum;
	logic               good;
	logic               out_free;

	// The result slot is free when empty or being emptied this cycle.
	assign out_free = !out_valid_q || result.ready;
	assign pop      = head_valid && (head_item.kind != KIND_END || out_free);

	// Next octet value: times ten by shifts, plus the new digit.
	assign digit_sum = {octet_value_q, 3'b000} + {2'b00, octet_value_q, 1'b0}
		+ {8'h00, head_item.digit};

	assign good = !error_seen_q && (octet_index_q == LAST_INDEX)
		&& (phase_q == PHASE_DIGITS) && (octet_value_q <= OCTET_MAX);

	// Parser state update, one classified character per cycle; a terminator is held while the result slot is not free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octet_index_q <= '0;
			phase_q       <= PHASE_FIRST;
			octet_value_q <= '0;
			address_acc_q <= '0;
			error_seen_q  <= 1'b0;
		end else if (pop) begin
			case (head_item.kind)
				KIND_END: begin
					octet_index_q <= '0;
					phase_q       <= PHASE_FIRST;
					octet_value_q <= '0;
					address_acc_q <= '0;
					error_seen_q  <= 1'b0;
				end
				KIND_DIGIT: begin
					if (!error_seen_q) begin
						phase_q <= PHASE_DIGITS;
						if (digit_sum > 12'(OCTET_MAX)) begin
							octet_value_q <= OCTET_SAT;
							error_seen_q  <= 1'b1;
						end else begin
							octet_value_q <= digit_sum[OCTET_W-1:0];
						end
					end
				end
				KIND_DOT: begin
					if (!error_seen_q) begin
						if (phase_q == PHASE_DIGITS && octet_index_q < LAST_INDEX
							&& octet_value_q <= OCTET_MAX) begin
							address_acc_q <= {address_acc_q[15:0], octet_value_q[7:0]};
							octet_index_q <= octet_index_q + 2'd1;
							phase_q       <= PHASE_FIRST;
							octet_value_q <= '0;
						end else begin
							error_seen_q <= 1'b1;
						end
					end
				end
				default: begin
					error_seen_q <= 1'b1;
				end
			endcase
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head_item.kind == KIND_END) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded on the terminator.
	always_ff @(posedge clk) begin
		if (pop && head_item.kind == KIND_END) begin
			out_error_q   <= !good;
			out_address_q <= good ? {address_acc_q, octet_value_q[7:0]} : 32'h0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.address     = out_address_q;
	assign result.parse_error = out_error_q;

endmodule

>>> sv/ipv4_dotted_decimal_parser.sv
// Top level of the IPv4 dotted-decimal parser: front end, queue and back end.
// Depends on ipv4p_pkg, ipv4p_if, ipv4p_front, ipv4p_queue and ipv4p_back.
//
//   Channel  Direction  Payload                 Transaction
//   chars    in         char_in[7:0]            one character, 0 ends the string
//   result   out        address[31:0], err      one per terminator
//
// One character is taken every cycle; a character is written into the queue and from
// there into the parser state, and a result is visible the cycle after the
// terminator is parsed. The two-entry queue lets input continue while a result
// waits; input stalls only when the queue is full behind a held terminator.
// arst_n clears the parser state, the queue and the result flag.
module ipv4_dotted_decimal_parser (
	input  logic            clk,
	input  logic            arst_n,
	ipv4p_char_if.sink      chars,
	ipv4p_result_if.source  result
);
	import ipv4p_pkg::*;

	ipv4p_item_t push_item;
	logic        push_valid;
	logic        push_ready;
	ipv4p_item_t head_item;
	logic        head_valid;
	logic        pop;

	// Character classification.
	ipv4p_front u_front (
		.chars      (chars),
		.item       (push_item),
		.item_valid (push_valid),
		.item_ready (push_ready)
	);

	// Decoupling queue.
	ipv4p_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.head_item  (head_item),
		.head_valid (head_valid),
		.pop        (pop)
	);

	// Octet parser and result register.
	ipv4p_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_item  (head_item),
		.head_valid (head_valid),
		.pop        (pop),
		.result     (result)
	);

endmodule

>>> test/ipv4_dotted_decimal_parser_test.sv
// Self-checking testbench for the IPv4 dotted-decimal parser: drives address strings
// one character per transaction and checks every parsed address against a predictor.
// Depends on ipv4p_pkg, the channel interfaces in ipv4p_if and the parser top level.
module ipv4_dotted_decimal_parser_test;
	import ipv4p_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 8;
	localparam int IDLE_PCT       = 15;
	localparam int CHAR_COUNT     = 1050;
	localparam int STEADY_FIRST   = 400;
	localparam int STEADY_LAST    = 650;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;
	localparam int RADIX          = 10;

	// One parsed address as it leaves the block.
	typedef struct packed {
		logic [31:0] address;
		logic        parse_error;
	} parse_result_t;

	// Shapes of generated address strings.
	typedef enum {
		TXT_GOOD,
		TXT_EXTRA_OCTET,
		TXT_SHORT,
		TXT_TRAILING_DOT,
		TXT_LEADING_DOT,
		TXT_DOUBLE_DOT,
		TXT_OVERFLOW,
		TXT_STRAY_CHAR,
		TXT_EMPTY,
		TXT_NOISE
	} text_shape_t;

	// Tracks the parser state and checks parsed addresses in order.
	class address_scoreboard;
		logic [2:0]    octets_done;
		parse_phase_t  phase;
		logic [8:0]    octet_acc;
		logic [31:0]   address_acc;
		bit            bad_text;
		parse_result_t expected_results[$];
		int unsigned   failures;

		function new();
			failures = 0;
			restart();
		endfunction

		function void restart();
			octets_done = '0;
			phase = PHASE_FIRST;
			octet_acc = '0;
			address_acc = '0;
			bad_text = 1'b0;
		endfunction

		// Advances the parser state by one accepted character.
		function void note_char(logic [7:0] c);
			int unsigned   v;
			parse_result_t r;
			if (c == CHAR_END) begin
				if (!bad_text && octets_done == LAST_INDEX && phase == PHASE_DIGITS &&
				    octet_acc <= OCTET_MAX) begin
					r.address = {address_acc[23:0], octet_acc[7:0]};
					r.parse_error = 1'b0;
				end else begin
					r.address = '0;
					r.parse_error = 1'b1;
				end
				expected_results.push_back(r);
				restart();
			end else if (!bad_text) begin
				if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
					v = 32'(octet_acc) * RADIX + 32'(c - CHAR_ZERO);
					// The octet saturates rather than wrapping, and is flagged at once.
					if (v > OCTET_MAX) begin
						v = OCTET_SAT;
						bad_text = 1'b1;
					end
					octet_acc = v[8:0];
					phase = PHASE_DIGITS;
				end else if (c == CHAR_DOT && phase == PHASE_DIGITS &&
				             octets_done < LAST_INDEX && octet_acc <= OCTET_MAX) begin
					address_acc = {address_acc[23:0], octet_acc[7:0]};
					octets_done = octets_done + 1'b1;
					phase = PHASE_FIRST;
					octet_acc = '0;
				end else begin
					bad_text = 1'b1;
				end
			end
		endfunction

		function void check_result(logic [31:0] address, logic parse_error);
			parse_result_t r;
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result: address %h error %b", address, parse_error);
			end else begin
				r = expected_results.pop_front();
				if (r.address !== address || r.parse_error !== parse_error) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("result mismatch: expected address %h error %b, got address %h error %b",
						         r.address, r.parse_error, address, parse_error);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	int   sent_chars;
	int   quiet_cycles;
	logic [7:0] line_buf[$];
	address_scoreboard sb = new();

	ipv4p_char_if   chars_if();
	ipv4p_result_if result_if();

	ipv4_dotted_decimal_parser uut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.result (result_if)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Result side: check accepted results, stall at random, and watch for a hang.
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			sb.check_result(result_if.address, result_if.parse_error);
		result_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		if ((chars_if.valid && chars_if.ready) || (result_if.valid && result_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** ipv4_dotted_decimal_parser: FAILED **");
			$finish;
		end
	end

	// Sends one character and notes it once the transaction completes.
	task automatic send_char(input logic [7:0] c);
		steady = (sent_chars >= STEADY_FIRST && sent_chars < STEADY_LAST);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.char_in <= c;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		sb.note_char(c);
		sent_chars++;
	endtask

	// Sends the buffered string followed by its terminator.
	task automatic send_line();
		foreach (line_buf[i])
			send_char(line_buf[i]);
		send_char(CHAR_END);
		line_buf.delete();
	endtask

	function automatic void add_text(string s);
		foreach (s[i])
			line_buf.push_back(s[i]);
	endfunction

	// Appends an octet, sometimes with leading zeros; extremes come up often.
	function automatic void add_octet(bit overflow);
		int unsigned value;
		int unsigned run;
		if (overflow) begin
			if ($urandom_range(0, 1) == 0) begin
				add_text($sformatf("%0d", $urandom_range(256, 999)));
			end else begin
				// Long digit run that saturates the accumulator.
				run = $urandom_range(4, 12);
				line_buf.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
				repeat (run - 1)
					line_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
			end
		end else begin
			case ($urandom_range(0, 3))
				0: value = 0;
				1: value = 255;
				default: value = $urandom_range(0, 255);
			endcase
			if ($urandom_range(0, 9) < 2)
				repeat ($urandom_range(1, 2))
					line_buf.push_back(CHAR_ZERO);
			add_text($sformatf("%0d", value));
		end
	endfunction

	// Appends dot-separated octets; the slot arguments place a fault, or -1 for none.
	function automatic void add_dotted(int count, int overflow_slot, int double_slot);
		for (int i = 0; i < count; i++) begin
			if (i > 0)
				line_buf.push_back(CHAR_DOT);
			if (i == double_slot)
				line_buf.push_back(CHAR_DOT);
			add_octet(i == overflow_slot);
		end
	endfunction

	function automatic text_shape_t pick_shape();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return TXT_GOOD;
		if (r < 60) return TXT_EXTRA_OCTET;
		if (r < 65) return TXT_SHORT;
		if (r < 70) return TXT_TRAILING_DOT;
		if (r < 74) return TXT_LEADING_DOT;
		if (r < 78) return TXT_DOUBLE_DOT;
		if (r < 84) return TXT_OVERFLOW;
		if (r < 90) return TXT_STRAY_CHAR;
		if (r < 94) return TXT_EMPTY;
		return TXT_NOISE;
	endfunction

	function automatic logic [7:0] stray_char();
		logic [7:0] ch;
		do
			ch = 8'($urandom_range(1, 255));
		while ((ch >= CHAR_ZERO && ch <= CHAR_NINE) || ch == CHAR_DOT);
		return ch;
	endfunction

	// Stimulus: reset, a few directed strings, then random strings of every shape.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		steady = 1'b0;
		sent_chars = 0;
		quiet_cycles = 0;
		chars_if.valid = 1'b0;
		chars_if.char_in = '0;
		result_if.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Empty string, extreme octets, then an overflow followed by ignored characters.
		send_line();
		add_text("255.0.9.199");
		send_line();
		add_text("2560");
		line_buf.push_back(8'hFF);
		add_text(".");
		send_line();

		while (sent_chars < CHAR_COUNT) begin
			case (pick_shape())
				TXT_GOOD:         add_dotted(4, -1, -1);
				TXT_EXTRA_OCTET:  add_dotted($urandom_range(5, 6), -1, -1);
				TXT_SHORT:        add_dotted($urandom_range(1, 3), -1, -1);
				TXT_TRAILING_DOT: begin
					add_dotted(4, -1, -1);
					line_buf.push_back(CHAR_DOT);
				end
				TXT_LEADING_DOT: begin
					line_buf.push_back(CHAR_DOT);
					add_dotted(4, -1, -1);
				end
				TXT_DOUBLE_DOT:   add_dotted(4, -1, $urandom_range(1, 3));
				TXT_OVERFLOW:     add_dotted(4, $urandom_range(0, 3), -1);
				TXT_STRAY_CHAR: begin
					add_dotted(4, -1, -1);
					line_buf.insert($urandom_range(0, line_buf.size()), stray_char());
				end
				TXT_EMPTY: ;
				TXT_NOISE: begin
					repeat ($urandom_range(1, 16))
						line_buf.push_back(8'($urandom_range(1, 255)));
				end
			endcase
			send_line();
		end
		chars_if.valid <= 1'b0;

		// Drain the remaining results, then allow for the pipeline to settle.
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.expected_results.size() == 0)
			$display("** ipv4_dotted_decimal_parser: PASSED **");
		else
			$display("** ipv4_dotted_decimal_parser: FAILED **");
		$finish;
	end
endmodule
